// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MIPP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define MIPP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define MIPP_ASSERT(lbl, clk, rstn, prop)
`define MIPP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hw/rtl/mipp_pkg.sv =====
`timescale 1ns / 1ps

package mipp_pkg;

	localparam int unsigned TOPIC_BUFFER = 128;
	localparam logic [16:0] TOPIC_LIMIT  = 17'(TOPIC_BUFFER - 1);

	localparam logic [15:0] CAP_RESET    = 16'd512;
	localparam logic [3:0]  PUBLISH_TYPE = 4'h3;
	localparam logic [7:0]  PUBACK_HDR   = 8'h40;
	localparam logic [7:0]  PUBACK_LEN   = 8'h02;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_LEN       = 3'd1,
		PH_SKIP_BIG  = 3'd2,
		PH_SKIP_REST = 3'd3,
		PH_TLEN      = 3'd4,
		PH_TOPIC     = 3'd5,
		PH_ID        = 3'd6,
		PH_PAYLOAD   = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TOPIC   = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_PUBACK  = 2'd2,
		KIND_STATUS  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_DELIVERED = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_OTHER     = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_MALFORMED = 3'd4,
		ST_TIMEOUT   = 3'd5
	} status_t;

	// Results caused by one request: optional stream byte, optional
	// status, optional PUBACK, plus the packet fields they all carry.
	typedef struct packed {
		logic        data_vld;
		logic        data_payload;
		logic [7:0]  data_byte;
		logic        stat_vld;
		status_t     status;
		logic        puback;
		logic [1:0]  qos;
		logic [15:0] packet_id;
		logic [3:0]  packet_type;
		logic        topic_truncated;
	} grp_t;

endpackage

// ===== hw/rtl/mipp_stream_if.sv =====
`timescale 1ns / 1ps

interface mipp_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] in_byte;

	modport source(output valid, func, in_byte, input ready);
	modport sink(input valid, func, in_byte, output ready);
endinterface

interface mipp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [7:0]  out_byte;
	logic        out_last;
	logic [2:0]  out_status;
	logic [1:0]  out_qos;
	logic [15:0] out_packet_id;
	logic [3:0]  out_packet_type;
	logic        out_topic_truncated;

	modport source(output valid, out_kind, out_byte, out_last, out_status, out_qos,
		out_packet_id, out_packet_type, out_topic_truncated, input ready);
	modport sink(input valid, out_kind, out_byte, out_last, out_status, out_qos,
		out_packet_id, out_packet_type, out_topic_truncated, output ready);
endinterface

// ===== hw/rtl/mipp_parse.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mipp_parse (
	input  logic              clk,
	input  logic              arst_n,
	mipp_in_if.sink           item,
	input  logic [15:0]       cap,
	output mipp_pkg::grp_t    grp,
	output logic              grp_vld,
	input  logic              grp_take
);

	logic       vld_s1;
	logic       func_s1;
	logic [7:0] byte_s1;

	mipp_pkg::phase_t phase_q, phase_d;
	logic [7:0]  header_q, header_d;
	logic [27:0] rl_q, rl_d;
	logic [2:0]  lbc_q, lbc_d;
	logic [27:0] bl_q, bl_d;
	logic [15:0] tl_q, tl_d;
	logic [15:0] tc_q, tc_d;
	logic [15:0] pid_q, pid_d;
	logic [1:0]  icnt_q, icnt_d;

	logic              fin;
	mipp_pkg::status_t fin_code;
	logic              adv;

	// shared predicates
	logic        tmo;
	logic        pub_q;
	logic [1:0]  qos_q;
	logic [27:0] bl_m1;
	logic [27:0] rl_add;
	logic [27:0] rl_new;
	logic [2:0]  lbc_new;
	logic        len_end;
	logic        total_big;
	logic [15:0] tl_new;
	logic [27:0] need;
	logic        need_gt;
	logic [15:0] tc_new;
	logic        topic_end;
	logic        pair_end;
	logic        pub_d;

	assign tmo     = func_s1;
	assign pub_q   = (header_q[7:4] == mipp_pkg::PUBLISH_TYPE);
	assign qos_q   = pub_q ? header_q[2:1] : 2'd0;
	assign bl_m1   = bl_q - 28'd1;
	assign lbc_new = lbc_q + 3'd1;
	assign len_end = !byte_s1[7] || (lbc_new == 3'd4);

	always_comb begin
		unique case (lbc_q[1:0])
			2'd0: rl_add = {21'd0, byte_s1[6:0]};
			2'd1: rl_add = {14'd0, byte_s1[6:0], 7'd0};
			2'd2: rl_add = {7'd0, byte_s1[6:0], 14'd0};
			default: rl_add = {byte_s1[6:0], 21'd0};
		endcase
	end

	assign rl_new    = rl_q | rl_add;
	assign total_big = ({1'b0, rl_new} + 29'(lbc_new) + 29'd1) > {13'd0, cap};
	assign tl_new    = {tl_q[7:0], byte_s1};
	assign need      = {12'd0, tl_new} + ((qos_q != 2'd0) ? 28'd2 : 28'd0);
	assign need_gt   = need > bl_m1;
	assign tc_new    = tc_q + 16'd1;
	assign topic_end = tc_new >= tl_q;
	assign pair_end  = (icnt_q == 2'd1);

	// next state: phase and packet end
	always_comb begin
		phase_d  = phase_q;
		fin      = 1'b0;
		fin_code = mipp_pkg::ST_DELIVERED;
		if (tmo) begin
			if (phase_q != mipp_pkg::PH_IDLE) begin
				fin      = 1'b1;
				fin_code = mipp_pkg::ST_TIMEOUT;
			end
		end else begin
			unique case (phase_q)
				mipp_pkg::PH_IDLE: phase_d = mipp_pkg::PH_LEN;
				mipp_pkg::PH_LEN: begin
					if (len_end) begin
						priority if (total_big) begin
							phase_d  = mipp_pkg::PH_SKIP_BIG;
							fin      = (rl_new == 28'd0);
							fin_code = mipp_pkg::ST_TOO_LARGE;
						end else if (!pub_q) begin
							phase_d  = mipp_pkg::PH_SKIP_REST;
							fin      = (rl_new == 28'd0);
							fin_code = mipp_pkg::ST_OTHER;
						end else if (rl_new < 28'd2) begin
							phase_d  = mipp_pkg::PH_SKIP_REST;
							fin      = (rl_new == 28'd0);
							fin_code = mipp_pkg::ST_MALFORMED;
						end else begin
							phase_d = mipp_pkg::PH_TLEN;
						end
					end
				end
				mipp_pkg::PH_SKIP_BIG, mipp_pkg::PH_SKIP_REST: begin
					fin = (bl_m1 == 28'd0);
					priority if (phase_q == mipp_pkg::PH_SKIP_BIG)
						fin_code = mipp_pkg::ST_TOO_LARGE;
					else if (pub_q)
						fin_code = mipp_pkg::ST_MALFORMED;
					else
						fin_code = mipp_pkg::ST_OTHER;
				end
				mipp_pkg::PH_TLEN: begin
					if (pair_end) begin
						priority if (need_gt) begin
							phase_d  = mipp_pkg::PH_SKIP_REST;
							fin      = (bl_m1 == 28'd0);
							fin_code = mipp_pkg::ST_MALFORMED;
						end else if (tl_new != 16'd0) begin
							phase_d = mipp_pkg::PH_TOPIC;
						end else if (qos_q != 2'd0) begin
							phase_d = mipp_pkg::PH_ID;
						end else if (bl_m1 != 28'd0) begin
							phase_d = mipp_pkg::PH_PAYLOAD;
						end else begin
							fin      = 1'b1;
							fin_code = mipp_pkg::ST_EMPTY;
						end
					end
				end
				mipp_pkg::PH_TOPIC: begin
					if (topic_end) begin
						priority if (qos_q != 2'd0) begin
							phase_d = mipp_pkg::PH_ID;
						end else if (bl_m1 != 28'd0) begin
							phase_d = mipp_pkg::PH_PAYLOAD;
						end else begin
							fin      = 1'b1;
							fin_code = mipp_pkg::ST_EMPTY;
						end
					end
				end
				mipp_pkg::PH_ID: begin
					if (pair_end) begin
						if (bl_m1 != 28'd0) begin
							phase_d = mipp_pkg::PH_PAYLOAD;
						end else begin
							fin      = 1'b1;
							fin_code = mipp_pkg::ST_EMPTY;
						end
					end
				end
				mipp_pkg::PH_PAYLOAD: begin
					fin      = (bl_m1 == 28'd0);
					fin_code = mipp_pkg::ST_DELIVERED;
				end
			endcase
		end
		if (fin) phase_d = mipp_pkg::PH_IDLE;
	end

	// next values of the packet registers
	always_comb begin
		header_d = header_q;
		rl_d     = rl_q;
		lbc_d    = lbc_q;
		bl_d     = bl_q;
		tl_d     = tl_q;
		tc_d     = tc_q;
		pid_d    = pid_q;
		icnt_d   = icnt_q;
		if (!tmo) begin
			unique case (phase_q)
				mipp_pkg::PH_IDLE: begin
					header_d = byte_s1;
					rl_d     = 28'd0;
					lbc_d    = 3'd0;
					bl_d     = 28'd0;
					tl_d     = 16'd0;
					tc_d     = 16'd0;
					pid_d    = 16'd0;
					icnt_d   = 2'd0;
				end
				mipp_pkg::PH_LEN: begin
					rl_d  = rl_new;
					lbc_d = lbc_new;
					if (len_end) begin
						bl_d   = rl_new;
						icnt_d = 2'd0;
					end
				end
				mipp_pkg::PH_TLEN: begin
					tl_d   = tl_new;
					bl_d   = bl_m1;
					icnt_d = icnt_q + 2'd1;
					if (pair_end) begin
						icnt_d = 2'd0;
						tc_d   = 16'd0;
					end
				end
				mipp_pkg::PH_TOPIC: begin
					tc_d = tc_new;
					bl_d = bl_m1;
				end
				mipp_pkg::PH_ID: begin
					pid_d  = {pid_q[7:0], byte_s1};
					bl_d   = bl_m1;
					icnt_d = icnt_q + 2'd1;
				end
				mipp_pkg::PH_SKIP_BIG, mipp_pkg::PH_SKIP_REST,
				mipp_pkg::PH_PAYLOAD: bl_d = bl_m1;
			endcase
		end
	end

	// outputs: result group of this request
	assign pub_d = (header_d[7:4] == mipp_pkg::PUBLISH_TYPE);

	always_comb begin
		grp.data_vld        = !tmo && (((phase_q == mipp_pkg::PH_TOPIC)
			&& ({1'b0, tc_q} < mipp_pkg::TOPIC_LIMIT)) || (phase_q == mipp_pkg::PH_PAYLOAD));
		grp.data_payload    = (phase_q == mipp_pkg::PH_PAYLOAD);
		grp.data_byte       = byte_s1;
		grp.stat_vld        = fin;
		grp.status          = fin_code;
		grp.qos             = pub_d ? header_d[2:1] : 2'd0;
		grp.puback          = fin && pub_d && (header_d[2:1] == 2'd1)
			&& ((fin_code == mipp_pkg::ST_DELIVERED) || (fin_code == mipp_pkg::ST_EMPTY));
		grp.packet_id       = pid_d;
		grp.packet_type     = header_d[7:4];
		grp.topic_truncated = pub_d && ({1'b0, tl_d} > mipp_pkg::TOPIC_LIMIT);
	end

	assign grp_vld    = vld_s1 && (grp.data_vld || grp.stat_vld);
	// advance when the request makes no result or the emitter takes its group
	assign adv        = vld_s1 && (!(grp.data_vld || grp.stat_vld) || grp_take);
	assign item.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			func_s1 <= item.func;
			byte_s1 <= item.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mipp_pkg::PH_IDLE;
			header_q <= 8'd0;
			rl_q     <= 28'd0;
			lbc_q    <= 3'd0;
			bl_q     <= 28'd0;
			tl_q     <= 16'd0;
			tc_q     <= 16'd0;
			pid_q    <= 16'd0;
			icnt_q   <= 2'd0;
		end else if (adv) begin
			phase_q  <= phase_d;
			header_q <= header_d;
			rl_q     <= rl_d;
			lbc_q    <= lbc_d;
			bl_q     <= bl_d;
			tl_q     <= tl_d;
			tc_q     <= tc_d;
			pid_q    <= pid_d;
			icnt_q   <= icnt_d;
		end
	end

	`MIPP_ASSERT(a_puback_with_status, clk, arst_n, grp_vld && grp.puback |-> grp.stat_vld)
	`MIPP_ASSERT(a_fin_to_idle, clk, arst_n, adv && grp.stat_vld |=> phase_q == mipp_pkg::PH_IDLE)
	`MIPP_ASSERT(a_payload_has_bytes, clk, arst_n, phase_q == mipp_pkg::PH_PAYLOAD |-> bl_q != 28'd0)
	`MIPP_ASSERT(a_hold_unless_adv, clk, arst_n, vld_s1 && !adv |=> vld_s1 && $stable(byte_s1))

endmodule

// ===== hw/rtl/mipp_emit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mipp_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  mipp_pkg::grp_t    grp,
	input  logic              grp_vld,
	output logic              grp_take,
	mipp_out_if.source        result
);

	// slot 0 stream byte, 1 status, 2..5 PUBACK bytes
	logic [5:0]     mask_s2;
	mipp_pkg::grp_t grp_s2;
	logic           single;
	logic           load;
	logic           fire;

	assign single   = ((mask_s2 & (mask_s2 - 6'd1)) == 6'd0);
	assign grp_take = (mask_s2 == 6'd0) || (result.ready && single);
	assign load     = grp_vld && grp_take;
	assign fire     = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= 6'd0;
		end else if (load) begin
			mask_s2 <= {{4{grp.puback}}, grp.stat_vld, grp.data_vld};
		end else if (fire) begin
			mask_s2 <= mask_s2 & (mask_s2 - 6'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) grp_s2 <= grp;
	end

	assign result.valid               = (mask_s2 != 6'd0);
	assign result.out_last            = single;
	assign result.out_qos             = grp_s2.qos;
	assign result.out_packet_id       = grp_s2.packet_id;
	assign result.out_packet_type     = grp_s2.packet_type;
	assign result.out_topic_truncated = grp_s2.topic_truncated;

	always_comb begin
		result.out_status = mipp_pkg::ST_DELIVERED;
		priority if (mask_s2[0]) begin
			result.out_kind = grp_s2.data_payload ? mipp_pkg::KIND_PAYLOAD
				: mipp_pkg::KIND_TOPIC;
			result.out_byte = grp_s2.data_byte;
		end else if (mask_s2[1]) begin
			result.out_kind   = mipp_pkg::KIND_STATUS;
			result.out_byte   = 8'd0;
			result.out_status = grp_s2.status;
		end else if (mask_s2[2]) begin
			result.out_kind = mipp_pkg::KIND_PUBACK;
			result.out_byte = mipp_pkg::PUBACK_HDR;
		end else if (mask_s2[3]) begin
			result.out_kind = mipp_pkg::KIND_PUBACK;
			result.out_byte = mipp_pkg::PUBACK_LEN;
		end else if (mask_s2[4]) begin
			result.out_kind = mipp_pkg::KIND_PUBACK;
			result.out_byte = grp_s2.packet_id[15:8];
		end else begin
			result.out_kind = mipp_pkg::KIND_PUBACK;
			result.out_byte = grp_s2.packet_id[7:0];
		end
	end

	`MIPP_ASSERT(a_group_continues, clk, arst_n, fire && !result.out_last |=> result.valid)
	`MIPP_ASSERT(a_puback_run, clk, arst_n, fire && !result.out_last && result.out_kind == mipp_pkg::KIND_PUBACK |=> result.out_kind == mipp_pkg::KIND_PUBACK)
	`MIPP_ASSERT(a_status_after_data, clk, arst_n, result.valid && result.out_kind == mipp_pkg::KIND_STATUS |-> !mask_s2[0])

endmodule

// ===== hw/rtl/mqtt_inbound_packet_parser_unit.sv =====
`timescale 1ns / 1ps

// Inbound MQTT 3.1.1 deframer. Each request on item carries one received byte
// (func 0) or a receive timeout (func 1). The block reads the fixed header and
// the one- to four-byte remaining length, drops packets larger than rx_capacity
// (header and length bytes counted, sampled at the last length byte), streams
// PUBLISH topic bytes (first TOPIC_BUFFER-1 only) and payload bytes, and closes
// each packet with a status request followed, for QoS 1 deliveries, by the four
// PUBACK bytes. A request makes zero to six result requests on result, the last
// one flagged by out_last. Rate: one item per cycle while result is ready and
// each item makes at most one result; an item with several results holds the
// single result port until its last result is taken, and items with no result
// do not wait on result. Results pass the input register, then the result
// register. rx_capacity resets to 512 and is written by cfg_we/cfg_wdata; the
// user must write it only while idle; the block itself does not enforce this.

module mqtt_inbound_packet_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	mipp_in_if.sink     item,
	mipp_out_if.source  result,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0]    cap_q;
	mipp_pkg::grp_t grp;
	logic           grp_vld;
	logic           grp_take;

	// hold the capacity register; update on a config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= mipp_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// input register, packet state and per-byte decode
	mipp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cap      (cap_q),
		.grp      (grp),
		.grp_vld  (grp_vld),
		.grp_take (grp_take)
	);

	// result register; drain one result per cycle while result is ready
	mipp_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp      (grp),
		.grp_vld  (grp_vld),
		.grp_take (grp_take),
		.result   (result)
	);

endmodule
